>>> rtl/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg: shared definitions of the radix digit string converter
// Widths, character codes, the padded width table and the item types that
// travel between the front end, the queue, the converter and the emitter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

	localparam int VALUE_BITS  = 64;
	localparam int RADIX_BITS  = 5;
	localparam int DIGIT_BITS  = 4;
	localparam int CHAR_BITS   = 7;
	localparam int NUM_DIGITS  = VALUE_BITS;
	localparam int IDX_BITS    = $clog2(NUM_DIGITS);
	localparam int PW_BITS     = VALUE_BITS + 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int RADIX_LO    = 2;
	localparam int RADIX_HI    = 16;
	localparam int TAB_SIZE    = 2 ** RADIX_BITS;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(RADIX_LO);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(RADIX_HI);

	localparam logic [DIGIT_BITS-1:0] DEC_DIGITS = DIGIT_BITS'(10);

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = CHAR_BITS'(8'h30);
	localparam logic [CHAR_BITS-1:0] CHAR_NINE = CHAR_BITS'(8'h39);
	localparam logic [CHAR_BITS-1:0] CHAR_A    = CHAR_BITS'(8'h41);
	localparam logic [CHAR_BITS-1:0] CHAR_F    = CHAR_BITS'(8'h46);

	typedef logic [TAB_SIZE-1:0][IDX_BITS-1:0]   width_tab_t;
	typedef logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits_t;

	// Classified input item as it waits in the queue.
	typedef struct packed {
		logic [VALUE_BITS-1:0] num;
		logic [RADIX_BITS-1:0] base;
		logic [IDX_BITS-1:0]   wm1;
		logic                  bad;
	} item_t;

	// Finished conversion handed from the converter to the emitter.
	typedef struct packed {
		digits_t             digs;
		logic [IDX_BITS-1:0] wm1;
		logic                bad;
	} result_t;

	// The padded width is the smallest n with base**n >= 2**VALUE_BITS.
	// The table holds that width minus one for every valid base.
	function automatic width_tab_t build_width_tab();
		width_tab_t          tab;
		logic [PW_BITS-1:0]  pw;
		int unsigned         cnt;
		tab = '0;
		for (int b = RADIX_LO; b <= RADIX_HI; b++) begin
			pw  = PW_BITS'(1);
			cnt = 0;
			for (int n = 0; n < VALUE_BITS; n++) begin
				if (pw[PW_BITS-1:VALUE_BITS] == '0) begin
					pw  = PW_BITS'(pw * PW_BITS'(b));
					cnt = cnt + 1;
				end
			end
			tab[b] = IDX_BITS'(cnt - 1);
		end
		return tab;
	endfunction

	localparam width_tab_t WIDTH_M1_TAB = build_width_tab();

	function automatic logic [CHAR_BITS-1:0] digit_glyph(logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] ch;
		if (d < DEC_DIGITS) begin
			ch = CHAR_ZERO + CHAR_BITS'(d);
		end else begin
			ch = CHAR_A + CHAR_BITS'(d - DEC_DIGITS);
		end
		return ch;
	endfunction

endpackage

>>> rtl/rdsc_front.sv
// ----------------------------------------------------------------------------
// rdsc_front: command intake and classification
// Registers an accepted command, checks the base and looks up the padded
// width, then offers the classified item to the queue.
// ----------------------------------------------------------------------------
module rdsc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rdsc_pkg::VALUE_BITS-1:0] number,
	input  logic [rdsc_pkg::RADIX_BITS-1:0] radix,
	input  logic                            q_full,
	output logic                            busy,
	output logic                            item_vld,
	output rdsc_pkg::item_t                 item
);

	logic                            vld_s1;
	logic [rdsc_pkg::VALUE_BITS-1:0] num_s1;
	logic [rdsc_pkg::RADIX_BITS-1:0] rad_s1;
	logic                            accept;
	logic                            bad;

	assign busy     = vld_s1 && q_full;
	assign accept   = start && !busy;
	assign item_vld = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_s1 <= number;
			rad_s1 <= radix;
		end
	end

	always_comb begin
		bad       = (rad_s1 < rdsc_pkg::RADIX_MIN) || (rad_s1 > rdsc_pkg::RADIX_MAX);
		item.num  = num_s1;
		item.base = rad_s1;
		item.bad  = bad;
		item.wm1  = bad ? '0 : rdsc_pkg::WIDTH_M1_TAB[rad_s1];
	end

endmodule

>>> rtl/rdsc_queue.sv
// ----------------------------------------------------------------------------
// rdsc_queue: short item queue
// A two-entry first-in first-out buffer that decouples the front end from
// the converter.
// ----------------------------------------------------------------------------
module rdsc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_vld,
	input  rdsc_pkg::item_t push_item,
	output logic            full,
	output logic            pop_vld,
	output rdsc_pkg::item_t pop_item,
	input  logic            pop
);

	rdsc_pkg::item_t                 entry_q [rdsc_pkg::QUEUE_DEPTH];
	logic [rdsc_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [rdsc_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [rdsc_pkg::QCNT_BITS-1:0]  cnt_q;
	logic                            push;
	logic                            do_pop;

	assign full     = (cnt_q == rdsc_pkg::QCNT_BITS'(rdsc_pkg::QUEUE_DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_item = entry_q[rd_ptr_q];
	assign push     = push_vld && !full;
	assign do_pop   = pop && pop_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/rdsc_conv.sv
// ----------------------------------------------------------------------------
// rdsc_conv: shift-and-double base converter
// Shifts the number in one bit per cycle, most significant first, and
// doubles a row of base-b digit cells. The carries between the cells are
// resolved by one wide add of their generate and propagate terms.
// ----------------------------------------------------------------------------
module rdsc_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_vld,
	input  rdsc_pkg::item_t   q_item,
	output logic              pop,
	output logic              res_vld,
	output rdsc_pkg::result_t res,
	input  logic              take
);

	localparam int N = rdsc_pkg::NUM_DIGITS;

	logic                            run_q;
	logic                            done_q;
	logic [rdsc_pkg::IDX_BITS-1:0]   cnt_q;
	logic [rdsc_pkg::VALUE_BITS-1:0] num_q;
	rdsc_pkg::digits_t               dig_q;
	rdsc_pkg::digits_t               dig_nx;
	logic [rdsc_pkg::RADIX_BITS-1:0] base_q;
	logic [rdsc_pkg::IDX_BITS-1:0]   wm1_q;
	logic                            bad_q;
	logic [N:0]                      pp;
	logic [N:0]                      gg;
	logic [N:0]                      sum;
	logic [N:0]                      carr;
	logic [rdsc_pkg::RADIX_BITS-1:0] dbl [N];

	assign pop     = q_vld && !run_q && (!done_q || take);
	assign res_vld = done_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			pp[i] = {dig_q[i], 1'b1} >= base_q;
			gg[i] = {dig_q[i], 1'b0} >= base_q;
		end
		pp[N] = 1'b0;
		gg[N] = 1'b0;
		sum     = pp + gg + (N + 1)'(num_q[rdsc_pkg::VALUE_BITS-1]);
		carr[0] = num_q[rdsc_pkg::VALUE_BITS-1];
		for (int i = 1; i <= N; i++) begin
			carr[i] = sum[i] ^ pp[i] ^ gg[i];
		end
		for (int i = 0; i < N; i++) begin
			dbl[i] = {dig_q[i], carr[i]};
			if (carr[i+1]) begin
				dig_nx[i] = rdsc_pkg::DIGIT_BITS'(dbl[i] - base_q);
			end else begin
				dig_nx[i] = dbl[i][rdsc_pkg::DIGIT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			run_q  <= !q_item.bad;
			done_q <= q_item.bad;
			cnt_q  <= rdsc_pkg::IDX_BITS'(rdsc_pkg::VALUE_BITS - 1);
		end else begin
			if (take) begin
				done_q <= 1'b0;
			end
			if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q  <= q_item.num;
			dig_q  <= '0;
			base_q <= q_item.base;
			wm1_q  <= q_item.wm1;
			bad_q  <= q_item.bad;
		end else if (run_q) begin
			num_q <= num_q << 1;
			dig_q <= dig_nx;
		end
	end

	always_comb begin
		res.digs = dig_q;
		res.wm1  = wm1_q;
		res.bad  = bad_q;
	end

endmodule

>>> rtl/rdsc_emit.sv
// ----------------------------------------------------------------------------
// rdsc_emit: digit character emitter
// Takes a finished conversion and sends its digits out most significant
// first, one character per cycle, or one error result for a bad base.
// ----------------------------------------------------------------------------
module rdsc_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_vld,
	input  rdsc_pkg::result_t              res,
	output logic                           take,
	output logic                           strobe,
	output logic [rdsc_pkg::CHAR_BITS-1:0] digit_char,
	output logic                           last_digit,
	output logic                           bad_radix
);

	localparam int N = rdsc_pkg::NUM_DIGITS;

	logic                           act_q;
	logic [rdsc_pkg::IDX_BITS-1:0]  cnt_q;
	logic [rdsc_pkg::IDX_BITS-1:0]  wm1_q;
	rdsc_pkg::digits_t              sreg_q;
	logic                           stb_q;
	logic [rdsc_pkg::CHAR_BITS-1:0] char_q;
	logic                           last_q;
	logic                           bad_q;

	assign take       = res_vld && !act_q;
	assign strobe     = stb_q;
	assign digit_char = char_q;
	assign last_digit = last_q;
	assign bad_radix  = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
			stb_q <= 1'b0;
		end else begin
			stb_q <= act_q || (take && res.bad);
			if (take) begin
				act_q <= !res.bad;
				cnt_q <= res.wm1;
			end else if (act_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_q) begin
			char_q <= rdsc_pkg::digit_glyph(sreg_q[wm1_q]);
			last_q <= (cnt_q == '0);
			bad_q  <= 1'b0;
			sreg_q <= {sreg_q[N-2:0], rdsc_pkg::DIGIT_BITS'(0)};
		end else if (take) begin
			sreg_q <= res.digs;
			wm1_q  <= res.wm1;
			char_q <= '0;
			last_q <= 1'b1;
			bad_q  <= res.bad;
		end
	end

endmodule

>>> rtl/radix_digit_string_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter: number to zero-padded digit string
// Converts a 64-bit unsigned number to its digits in a base from 2 to 16
// and sends them out as ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. The string is
// padded with leading zeros to the digit count of the largest 64-bit value
// in that base (64 digits in base 2, 20 in base 10, 16 in base 16). Every
// result is shown for exactly one cycle with strobe high and must be taken
// then; the final character carries last_digit. A base outside 2 to 16
// gives a single result with bad_radix and last_digit set and a zero
// character. The converter shifts in one bit of the number per cycle and
// runs while the previous string is being sent, which gives one digit per
// cycle on the output. A rejected base skips the conversion; its result
// passes through the front register, the queue, the converter's done flag
// and the emitter's output registers. Commands are held in a two-entry
// queue before the converter.
module radix_digit_string_converter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [63:0]                     number,
	input  logic [rdsc_pkg::RADIX_BITS-1:0] radix,
	output logic                            strobe,
	output logic [rdsc_pkg::CHAR_BITS-1:0]  digit_char,
	output logic                            last_digit,
	output logic                            bad_radix
);

	logic              front_vld;
	rdsc_pkg::item_t   front_item;
	logic              q_full;
	logic              q_vld;
	rdsc_pkg::item_t   q_item;
	logic              q_pop;
	logic              res_vld;
	rdsc_pkg::result_t res;
	logic              res_take;

	rdsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.number   (number[rdsc_pkg::VALUE_BITS-1:0]),
		.radix    (radix),
		.q_full   (q_full),
		.busy     (busy),
		.item_vld (front_vld),
		.item     (front_item)
	);

	rdsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (front_vld),
		.push_item (front_item),
		.full      (q_full),
		.pop_vld   (q_vld),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	rdsc_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_vld   (q_vld),
		.q_item  (q_item),
		.pop     (q_pop),
		.res_vld (res_vld),
		.res     (res),
		.take    (res_take)
	);

	rdsc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_vld    (res_vld),
		.res        (res),
		.take       (res_take),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.bad_radix  (bad_radix)
	);

	// An error result is a complete string of one zero character.
	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_radix |-> last_digit && (digit_char == '0))
		else $error("bad radix result without last flag or with a character");

	// Digits of one string leave on consecutive cycles with no gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_digit |=> strobe && !bad_radix)
		else $error("digit string interrupted");

	// Every digit result is a legal glyph.
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !bad_radix |->
			((digit_char >= rdsc_pkg::CHAR_ZERO) && (digit_char <= rdsc_pkg::CHAR_NINE)) ||
			((digit_char >= rdsc_pkg::CHAR_A) && (digit_char <= rdsc_pkg::CHAR_F)))
		else $error("digit character out of range");

endmodule
